/* design/trial_division_divisor_finder_assert.svh */
// Assertion macros for the port-level checker of the divisor finder.
`ifndef TRIAL_DIVISION_DIVISOR_FINDER_ASSERT_SVH
`define TRIAL_DIVISION_DIVISOR_FINDER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TDF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tdf same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TDF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tdf next-cycle check failed");

`endif

/* design/tdf_pkg.sv */
// Shared types and constants of the trial-division divisor finder.
package tdf_pkg;

  localparam int unsigned ADDR_W = 3;

  // Word index of the configuration registers
  localparam logic REG_SEARCH_MODE = 1'b0;

  // search_mode codes
  localparam logic MODE_FIRST = 1'b0;
  localparam logic MODE_EVERY = 1'b1;

  typedef struct packed {
    logic load;      // latch number, restart at candidate two
    logic div_init;  // start a remainder computation
    logic div_step;  // one restoring division step
    logic cand_inc;  // advance candidate
    logic hit;       // candidate divides: queue it, flush older one
    logic finish;    // emit final result
  } tdf_cmd_t;

  typedef struct packed {
    logic cand_lt_num;
    logic div_done;
    logic rem_zero;
  } tdf_stat_t;

endpackage

/* design/trial_division_divisor_finder.sv */
// Trial-division divisor finder: top level with the configuration register.
//
// Input: pulse start with in_number while busy is low; the transfer happens at
// that edge and busy rises for the whole search.
// Results: out_valid marks each result for one cycle with out_divisor,
// out_found and out_last; the receiver cannot stall, every result is taken.
// search_mode (APB, byte address 0, bit 0): 0 reports the smallest divisor
// only, 1 reports every divisor in rising order. Write it only while idle.
// Each candidate d from 2 to N-1 is tried in rising order: the remainder
// N mod d comes from a restoring divider that retires one dividend bit per
// cycle. First mode stops the search after the first hit.
// A divisor is shown only once the next one (or the end) is known, so the
// final result carries out_last; no divisor gives one result with
// out_found low and out_divisor zero. busy falls in the cycle of the final
// result, and a new start may be taken in that cycle.
// Reset (rst_n low, synchronous) returns to idle, drops out_valid and sets
// search_mode to first-divisor mode.
module trial_division_divisor_finder
  import tdf_pkg::*;
#(
  parameter int unsigned NUM_WIDTH = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [NUM_WIDTH-1:0] in_number,
  output logic                 out_valid,
  output logic [NUM_WIDTH-1:0] out_divisor,
  output logic                 out_found,
  output logic                 out_last,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic      search_mode_r;
  logic      reg_sel;
  tdf_cmd_t  cmd;
  tdf_stat_t stat;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[ADDR_W-1] == REG_SEARCH_MODE);
  assign prdata  = reg_sel ? {31'b0, search_mode_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_mode_r <= MODE_FIRST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      search_mode_r <= pwdata[0];
    end
  end

  tdf_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .search_mode (search_mode_r),
    .stat        (stat),
    .cmd         (cmd),
    .busy        (busy)
  );

  tdf_datapath #(
    .NUM_WIDTH (NUM_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_number   (in_number),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_divisor (out_divisor),
    .out_found   (out_found),
    .out_last    (out_last)
  );

endmodule

/* design/tdf_ctrl.sv */
// Controller state machine of the divisor finder.
module tdf_ctrl
  import tdf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      search_mode,
  input  tdf_stat_t stat,
  output tdf_cmd_t  cmd,
  output logic      busy
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CHECK  = 5'b00010,
    ST_DIV    = 5'b00100,
    ST_TEST   = 5'b01000,
    ST_FINISH = 5'b10000
  } tdf_state_t;

  tdf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.cand_lt_num) begin
          cmd.div_init = 1'b1;
          state_nxt    = ST_DIV;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_nxt = ST_TEST;
        end
      end
      ST_TEST: begin
        cmd.cand_inc = 1'b1;
        if (stat.rem_zero) begin
          cmd.hit   = 1'b1;
          state_nxt = (search_mode == MODE_FIRST) ? ST_FINISH : ST_CHECK;
        end else begin
          state_nxt = ST_CHECK;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

/* design/tdf_datapath.sv */
// Datapath: held number, candidate, bit-serial remainder and result registers.
module tdf_datapath
  import tdf_pkg::*;
#(
  parameter int unsigned NUM_WIDTH = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [NUM_WIDTH-1:0] in_number,
  input  tdf_cmd_t             cmd,
  output tdf_stat_t            stat,
  output logic                 out_valid,
  output logic [NUM_WIDTH-1:0] out_divisor,
  output logic                 out_found,
  output logic                 out_last
);

  localparam int unsigned CNT_W = (NUM_WIDTH > 1) ? $clog2(NUM_WIDTH) : 1;

  logic [NUM_WIDTH-1:0] num_r, cand_r, sh_r, rem_r, pend_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 pend_vld_r;
  logic                 out_valid_r, out_found_r, out_last_r;
  logic [NUM_WIDTH-1:0] out_divisor_r;

  logic [NUM_WIDTH:0]   trial;
  logic [NUM_WIDTH:0]   diff;
  logic [NUM_WIDTH-1:0] rem_nxt;

  // Restoring division step: shift in next dividend bit, subtract if it fits
  assign trial   = {rem_r, sh_r[NUM_WIDTH-1]};
  assign diff    = trial - {1'b0, cand_r};
  assign rem_nxt = (trial >= {1'b0, cand_r}) ? diff[NUM_WIDTH-1:0] : trial[NUM_WIDTH-1:0];

  assign stat.cand_lt_num = (cand_r < num_r);
  assign stat.div_done    = (cnt_r == CNT_W'(NUM_WIDTH - 1));
  assign stat.rem_zero    = (rem_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r       <= '0;
      cand_r      <= NUM_WIDTH'(2);
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.hit && pend_vld_r) || cmd.finish;
      if (cmd.load) begin
        num_r      <= in_number;
        cand_r     <= NUM_WIDTH'(2);
        pend_vld_r <= 1'b0;
      end
      if (cmd.cand_inc) begin
        cand_r <= cand_r + NUM_WIDTH'(1);
      end
      if (cmd.hit) begin
        pend_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      sh_r  <= num_r;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      sh_r  <= {sh_r[NUM_WIDTH-2:0], 1'b0};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + CNT_W'(1);
    end
    if (cmd.hit) begin
      pend_r <= cand_r;
    end
    // Each divisor is held until the next one or the end shows whether it is last
    if (cmd.hit) begin
      out_divisor_r <= pend_r;
      out_found_r   <= 1'b1;
      out_last_r    <= 1'b0;
    end else if (cmd.finish) begin
      out_divisor_r <= pend_vld_r ? pend_r : '0;
      out_found_r   <= pend_vld_r;
      out_last_r    <= 1'b1;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_divisor = out_divisor_r;
  assign out_found   = out_found_r;
  assign out_last    = out_last_r;

endmodule

/* design/trial_division_divisor_finder_chk.sv */
// Port-level checker for the divisor finder, bound to the top level.
`include "trial_division_divisor_finder_assert.svh"

module trial_division_divisor_finder_chk #(
  parameter int unsigned NUM_WIDTH = 12
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 out_valid,
  input logic [NUM_WIDTH-1:0] out_divisor,
  input logic                 out_found,
  input logic                 out_last
);

  // No-divisor result is always final and zero
  `TDF_ASSERT_NOW(a_none_is_final, out_valid && !out_found, out_last && (out_divisor == '0))
  // Results that are not final come while the search still runs
  `TDF_ASSERT_NOW(a_mid_while_busy, out_valid && !out_last, busy)
  // An accepted number starts a search
  `TDF_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !out_valid)
  // Final result frees the block
  `TDF_ASSERT_NOW(a_last_frees, out_valid && out_last, !busy)

endmodule

bind trial_division_divisor_finder trial_division_divisor_finder_chk #(
  .NUM_WIDTH (NUM_WIDTH)
) u_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .out_valid   (out_valid),
  .out_divisor (out_divisor),
  .out_found   (out_found),
  .out_last    (out_last)
);

/* tb/tb_top.sv */
// Self-checking testbench for the trial-division divisor finder.
`timescale 1ns / 1ps

module tb_top;
  import tdf_pkg::*;

  localparam int NW = 12;
  localparam int MAX_HITS = 46;
  localparam int IDLE_LIMIT = 250000;
  localparam int DRAIN_CYCLES = 30;
  localparam int PHASE_ITEMS = 29;
  localparam logic [ADDR_W-1:0] MODE_ADDR = {REG_SEARCH_MODE, 2'b00};
  // word 1 has no register behind it, writes there must be dropped
  localparam logic [ADDR_W-1:0] UNUSED_ADDR = ADDR_W'(4);

  typedef struct packed {
    logic [NW-1:0] divisor;
    logic          found;
    logic          last;
  } divisor_rec_t;

  class divisor_tracker;
    divisor_rec_t pending_divisors[$];
    logic         mode;
    int           bad_divisors;

    function new();
      mode = MODE_FIRST;
      bad_divisors = 0;
    endfunction

    function void write_reg(logic [ADDR_W-1:0] addr, logic [31:0] data);
      if (addr[ADDR_W-1:2] == REG_SEARCH_MODE) mode = data[0];
    endfunction

    // trial division over 2..n-1, same order the block reports
    function void take_number(logic [NW-1:0] n);
      int unsigned  hits[$];
      int unsigned  d;
      divisor_rec_t rec;
      for (d = 2; d < n; d++) begin
        if (n % d == 0) begin
          if (hits.size() < MAX_HITS) hits.push_back(d);
          if (mode == MODE_FIRST) break;
        end
      end
      if (hits.size() == 0) begin
        rec.divisor = '0;
        rec.found = 1'b0;
        rec.last = 1'b1;
        pending_divisors.push_back(rec);
      end else begin
        foreach (hits[i]) begin
          rec.divisor = NW'(hits[i]);
          rec.found = 1'b1;
          rec.last = (i == hits.size() - 1);
          pending_divisors.push_back(rec);
        end
      end
    endfunction

    function void match_divisor(logic [NW-1:0] d, logic f, logic l);
      divisor_rec_t want;
      if (pending_divisors.size() == 0) begin
        bad_divisors++;
        if (bad_divisors <= 10)
          $display("%0t: unexpected result divisor %0d found %b last %b", $realtime, d, f, l);
        return;
      end
      want = pending_divisors.pop_front();
      if (want.divisor !== d || want.found !== f || want.last !== l) begin
        bad_divisors++;
        if (bad_divisors <= 10)
          $display("%0t: expected divisor %0d found %b last %b, got divisor %0d found %b last %b",
                   $realtime, want.divisor, want.found, want.last, d, f, l);
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic [NW-1:0] in_number = '0;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]   pwdata = '0;
  logic          busy;
  logic          out_valid;
  logic [NW-1:0] out_divisor;
  logic          out_found;
  logic          out_last;
  logic [31:0]   prdata;
  logic          pready;

  divisor_tracker tracker;
  int burst_left = 0;
  int idle_cycles = 0;

  trial_division_divisor_finder #(.NUM_WIDTH(NW)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_number(in_number),
    .out_valid(out_valid), .out_divisor(out_divisor), .out_found(out_found),
    .out_last(out_last), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) tracker.match_divisor(out_divisor, out_found, out_last);
  end

  // watchdog: any cycle with a transfer on either side clears it
  always @(posedge clk) begin
    if (!rst_n || out_valid === 1'b1 || (start && busy === 1'b0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic cfg_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tracker.write_reg(addr, data);
  endtask

  // leaves start high; the caller lowers it when a gap follows or after the last number
  task automatic send_number(logic [NW-1:0] n);
    start <= 1'b1;
    in_number <= n;
    do @(posedge clk); while (busy !== 1'b0);
    tracker.take_number(n);
  endtask

  task automatic send_batch(int nums[$]);
    int gap;
    foreach (nums[i]) begin
      send_number(NW'(nums[i]));
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 8);
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 5);
      end else begin
        burst_left--;
        gap = 0;
      end
      if (gap > 0 || i == nums.size() - 1) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    // registers only change once the block is quiet
    while (tracker.pending_divisors.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mostly short searches; every-mode scans of large N are kept rare
  function automatic int pick_number(logic m);
    int r;
    int f;
    r = $urandom_range(0, 99);
    if (r < 8) return $urandom_range(0, 4);
    if (m == MODE_FIRST) begin
      if (r < 70) begin
        f = $urandom_range(2, 7);
        return f * $urandom_range(1, 4095 / f);
      end
      return $urandom_range(5, 500);
    end
    if (r < 97) return $urandom_range(5, 300);
    return $urandom_range(0, 4095);
  endfunction

  initial begin
    int   first_nums[$] = '{0, 1, 2, 3, 4, 5, 9, 4095, 4093, 2047, 4087, 2048};
    int   every_nums[$] = '{12, 0, 3, 4, 6, 13, 36, 360, 2048, 4095, 3360};
    int   draw[$];
    logic m;
    tracker = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // upper bits of the written value are dropped
    cfg_write(MODE_ADDR, 32'hFFFF_FFFE);
    cfg_write(UNUSED_ADDR, 32'hFFFF_FFFF);
    send_batch(first_nums);

    cfg_write(MODE_ADDR, 32'h0000_0001);
    cfg_write(UNUSED_ADDR, 32'h0000_0000);
    send_batch(every_nums);

    for (int ph = 0; ph < 4; ph++) begin
      m = (ph % 2 == 0) ? MODE_FIRST : MODE_EVERY;
      cfg_write(MODE_ADDR, ($urandom() & 32'hFFFF_FFFE) | 32'(m));
      if ($urandom_range(0, 1) == 1) cfg_write(UNUSED_ADDR, $urandom());
      draw.delete();
      repeat (PHASE_ITEMS) draw.push_back(pick_number(m));
      send_batch(draw);
    end

    if (tracker.bad_divisors == 0 && tracker.pending_divisors.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
